// ===== design/b64rd_pkg.sv =====
// Shared types, codes and the character classifier of the base64 run decoder.
package b64rd_pkg;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_PAD,
    KIND_SPACE,
    KIND_BAD
  } kind_e;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL    = 2'd1;
  localparam logic [1:0] ERR_EARLY_PAD  = 2'd2;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd3;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] val;
  } sym_t;

  // Results of one request: up to three bytes, entry 0 delivered first.
  typedef struct packed {
    logic [1:0]      count;
    logic [1:0]      err;
    logic [2:0][7:0] bytes;
  } res_t;

  function automatic sym_t classify(input logic [7:0] c);
    sym_t s;
    logic [7:0] off;
    s.kind = KIND_BAD;
    s.val  = 6'd0;
    off    = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      off    = c - 8'h41;
      s.kind = KIND_DIGIT;
      s.val  = off[5:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      off    = c - 8'h61 + 8'd26;
      s.kind = KIND_DIGIT;
      s.val  = off[5:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      off    = c - 8'h30 + 8'd52;
      s.kind = KIND_DIGIT;
      s.val  = off[5:0];
    end else if (c == 8'h2B) begin
      s.kind = KIND_DIGIT;
      s.val  = 6'd62;
    end else if (c == 8'h2F) begin
      s.kind = KIND_DIGIT;
      s.val  = 6'd63;
    end else if (c == 8'h3D) begin
      s.kind = KIND_PAD;
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      s.kind = KIND_SPACE;
    end
    return s;
  endfunction

endpackage

// ===== design/b64rd_char_if.sv =====
// Input channel: one character per request.
interface b64rd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_span;

  modport source (output valid, char_code, end_of_span, input ready);
  modport sink (input valid, char_code, end_of_span, output ready);
endinterface

// ===== design/b64rd_res_if.sv =====
// Output channel: one decoded byte or error per request.
interface b64rd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] error_code;
  logic       last_of_item;

  modport source (output valid, data_byte, error_code, last_of_item, input ready);
  modport sink (input valid, data_byte, error_code, last_of_item, output ready);
endinterface

// ===== design/b64rd_cfg_if.sv =====
// Configuration channel: writes the decode mode register.
interface b64rd_cfg_if;
  logic valid;
  logic ready;
  logic decode_base64;

  modport source (output valid, decode_base64, input ready);
  modport sink (input valid, decode_base64, output ready);
endinterface

// ===== design/b64rd_group.sv =====
// Group state of the decoder and the per-character decode into result bytes.
module b64rd_group
  import b64rd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       decode_i,
  input  logic [7:0] char_i,
  input  logic       eos_i,
  output res_t       res_o
);

  logic [5:0] d0_q, d1_q, d2_q, d0_d, d1_d, d2_d;
  logic       pad2_q, pad2_d;
  logic [1:0] cnt_q, cnt_d;
  sym_t       sym;

  always_comb begin
    sym          = classify(char_i);
    d0_d         = d0_q;
    d1_d         = d1_q;
    d2_d         = d2_q;
    pad2_d       = pad2_q;
    cnt_d        = cnt_q;
    res_o.count  = 2'd0;
    res_o.err    = ERR_NONE;
    res_o.bytes  = '0;
    if (!decode_i) begin
      res_o.count    = 2'd1;
      res_o.bytes[0] = char_i;
    end else begin
      case (sym.kind)
        KIND_BAD: begin
          res_o.count = 2'd1;
          res_o.err   = ERR_ILLEGAL;
        end
        KIND_SPACE: begin
          if (eos_i && cnt_q != 2'd0) begin
            res_o.count = 2'd1;
            res_o.err   = ERR_INCOMPLETE;
          end
        end
        KIND_DIGIT, KIND_PAD: begin
          if (sym.kind == KIND_PAD && cnt_q < 2'd2) begin
            res_o.count = 2'd1;
            res_o.err   = ERR_EARLY_PAD;
          end else if (cnt_q == 2'd3) begin
            res_o.bytes[0] = {d0_q, d1_q[5:4]};
            res_o.bytes[1] = {d1_q[3:0], d2_q[5:2]};
            res_o.bytes[2] = {d2_q[1:0], sym.val};
            if (pad2_q) begin
              res_o.count = 2'd1;
            end else if (sym.kind == KIND_PAD) begin
              res_o.count = 2'd2;
            end else begin
              res_o.count = 2'd3;
            end
          end else begin
            cnt_d = cnt_q + 2'd1;
            case (cnt_q)
              2'd0:    d0_d = sym.val;
              2'd1:    d1_d = sym.val;
              default: begin
                d2_d   = sym.val;
                pad2_d = (sym.kind == KIND_PAD);
              end
            endcase
            if (eos_i) begin
              res_o.count = 2'd1;
              res_o.err   = ERR_INCOMPLETE;
            end
          end
        end
        default: begin
          res_o.count = 2'd0;
        end
      endcase
      // Every result in decode mode closes the open group.
      if (res_o.count != 2'd0 || (sym.kind == KIND_SPACE && eos_i)) begin
        d0_d   = 6'd0;
        d1_d   = 6'd0;
        d2_d   = 6'd0;
        pad2_d = 1'b0;
        cnt_d  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_q   <= 6'd0;
      d1_q   <= 6'd0;
      d2_q   <= 6'd0;
      pad2_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (fire_i) begin
      d0_q   <= d0_d;
      d1_q   <= d1_d;
      d2_q   <= d2_d;
      pad2_q <= pad2_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== design/base64_run_decoder.sv =====
// Base64 run decoder: one character per request in, one byte or error per request out.
// A character is captured in the input register and decoded once the result register is
// free; its first result is then offered from the result register.
// Throughput: one character per cycle while each gives at most one result and the output
// takes it; a completed group holds the result register until all its bytes are taken.
// Reset clears the open group and the result register and selects base64 decode mode.
module base64_run_decoder
  import b64rd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  b64rd_char_if.sink   char_i,
  b64rd_res_if.source  result_o,
  b64rd_cfg_if.sink    cfg_i
);

  logic            decode_q;
  logic            in_vld_q;
  logic [7:0]      in_char_q;
  logic            in_eos_q;
  logic [1:0]      rem_q, rem_d;
  logic [1:0]      err_q, err_d;
  logic [2:0][7:0] bytes_q, bytes_d;
  logic            pop, buf_free, advance, in_acc;
  res_t            res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_q <= 1'b1;
    end else if (cfg_i.valid) begin
      decode_q <= cfg_i.decode_base64;
    end
  end

  assign pop          = result_o.valid && result_o.ready;
  assign buf_free     = (rem_q == 2'd0) || (pop && rem_q == 2'd1);
  assign advance      = in_vld_q && buf_free;
  assign char_i.ready = !in_vld_q || advance;
  assign in_acc       = char_i.valid && char_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (char_i.ready) begin
      in_vld_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_char_q <= char_i.char_code;
      in_eos_q  <= char_i.end_of_span;
    end
  end

  b64rd_group u_group (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .decode_i (decode_q),
    .char_i   (in_char_q),
    .eos_i    (in_eos_q),
    .res_o    (res)
  );

  always_comb begin
    rem_d   = rem_q;
    err_d   = err_q;
    bytes_d = bytes_q;
    if (advance) begin
      rem_d   = res.count;
      err_d   = res.err;
      bytes_d = res.bytes;
    end else if (pop) begin
      rem_d   = rem_q - 2'd1;
      bytes_d = {8'h00, bytes_q[2:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    bytes_q <= bytes_d;
  end

  assign result_o.valid        = (rem_q != 2'd0);
  assign result_o.data_byte    = bytes_q[0];
  assign result_o.error_code   = err_q;
  assign result_o.last_of_item = (rem_q == 2'd1);

  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && err_q != ERR_NONE) |-> (rem_q == 2'd1))
    else $error("error result is not the only result of its character");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && err_q != ERR_NONE) |-> (bytes_q[0] == 8'h00))
    else $error("error result carries a nonzero byte");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && rem_q > 2'd1) |=> (result_o.valid && !$past(advance)))
    else $error("pending results lost while draining a group");

  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_char_q)))
    else $error("held character changed before it was decoded");

endmodule
